// ===== hdl/rcs_pkg.sv =====
package rcs_pkg;

  localparam int unsigned FRAC_BITS = 16;

  // quotient bits resolved by the divider before saturation takes over
  localparam int unsigned QBITS = 33;

  // depth of the queue between classifier and solver (power of two)
  localparam int unsigned QDEPTH = 4;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_Y_MIN = 2'd0,
    CFG_Y_MAX = 2'd1,
    CFG_EPS   = 2'd2
  } cfg_idx_e;

  // bound values that mean "unbounded"
  localparam logic signed [31:0] Y_NO_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Y_NO_MAX = 32'sh7FFF_FFFF;
  localparam logic [15:0] EPS_RESET = 16'd1;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic              near_valid;
    logic signed [31:0] near_t;
    logic              far_valid;
    logic signed [31:0] far_t;
  } hit_t;

  // classified ray handed from front to back
  typedef struct packed {
    logic               ok;
    logic signed [64:0] h;
    logic [63:0]        a;
    logic [127:0]       d;
    logic signed [31:0] oy;
    logic signed [31:0] dy;
  } cls_t;

endpackage

// ===== hdl/rcs_ray_if.sv =====
interface rcs_ray_if;
  logic          valid;
  logic          ready;
  rcs_pkg::ray_t ray;

  modport source(output valid, output ray, input ready);
  modport sink(input valid, input ray, output ready);
endinterface

// ===== hdl/rcs_hit_if.sv =====
interface rcs_hit_if;
  logic          valid;
  logic          ready;
  rcs_pkg::hit_t hit;

  modport source(output valid, output hit, input ready);
  modport sink(input valid, input hit, output ready);
endinterface

// ===== hdl/rcs_front.sv =====
module rcs_front #(
  parameter int unsigned FRAC_BITS = rcs_pkg::FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rcs_pkg::ray_t in_i,
  input  logic [15:0]   eps_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rcs_pkg::cls_t out_o
);

  localparam logic [63:0] ONE2 = 64'(1) << (2 * FRAC_BITS);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign en          = !v5_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage 1: squares and cross products
  logic [63:0]        dxx_q, dzz_q, oxx_q, ozz_q;
  logic signed [63:0] oxd_q, ozd_q;
  logic signed [31:0] oy1_q, dy1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dxx_q <= 64'(in_i.dir_x * in_i.dir_x);
      dzz_q <= 64'(in_i.dir_z * in_i.dir_z);
      oxx_q <= 64'(in_i.origin_x * in_i.origin_x);
      ozz_q <= 64'(in_i.origin_z * in_i.origin_z);
      oxd_q <= 64'(in_i.origin_x * in_i.dir_x);
      ozd_q <= 64'(in_i.origin_z * in_i.dir_z);
      oy1_q <= in_i.origin_y;
      dy1_q <= in_i.dir_y;
    end
  end

  // stage 2: a, |c|, h
  logic [63:0]        csq;
  logic signed [64:0] h2;
  logic [63:0]        a2_q, cmag2_q, hm2_q;
  logic               cneg2_q;
  logic signed [64:0] h2_q;
  logic signed [31:0] oy2_q, dy2_q;

  assign csq = oxx_q + ozz_q;
  assign h2  = 65'(oxd_q) + 65'(ozd_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q    <= dxx_q + dzz_q;
      cneg2_q <= csq >= ONE2;
      cmag2_q <= (csq >= ONE2) ? (csq - ONE2) : (ONE2 - csq);
      h2_q    <= h2;
      hm2_q   <= h2[64] ? 64'(-h2) : h2[63:0];
      oy2_q   <= oy1_q;
      dy2_q   <= dy1_q;
    end
  end

  // stage 3: 32x32 partial products of a*|c| and h*h
  logic [63:0]        acll_q, aclh_q, achl_q, achh_q, hll_q, hlh_q, hhh_q;
  logic [63:0]        a3_q;
  logic               cneg3_q, oka3_q;
  logic signed [64:0] h3_q;
  logic signed [31:0] oy3_q, dy3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      acll_q  <= a2_q[31:0] * cmag2_q[31:0];
      aclh_q  <= a2_q[31:0] * cmag2_q[63:32];
      achl_q  <= a2_q[63:32] * cmag2_q[31:0];
      achh_q  <= a2_q[63:32] * cmag2_q[63:32];
      hll_q   <= hm2_q[31:0] * hm2_q[31:0];
      hlh_q   <= hm2_q[31:0] * hm2_q[63:32];
      hhh_q   <= hm2_q[63:32] * hm2_q[63:32];
      oka3_q  <= (a2_q != 64'd0) && (a2_q >= (64'(eps_i) << FRAC_BITS));
      a3_q    <= a2_q;
      cneg3_q <= cneg2_q;
      h3_q    <= h2_q;
      oy3_q   <= oy2_q;
      dy3_q   <= dy2_q;
    end
  end

  // stage 4: sum partials into full products
  logic [127:0]       ac4_q, hsq4_q;
  logic [63:0]        a4_q;
  logic               cneg4_q, oka4_q;
  logic signed [64:0] h4_q;
  logic signed [31:0] oy4_q, dy4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ac4_q   <= {achh_q, acll_q} + (128'(aclh_q) << 32) + (128'(achl_q) << 32);
      hsq4_q  <= {hhh_q, hll_q} + (128'(hlh_q) << 33);
      a4_q    <= a3_q;
      cneg4_q <= cneg3_q;
      oka4_q  <= oka3_q;
      h4_q    <= h3_q;
      oy4_q   <= oy3_q;
      dy4_q   <= dy3_q;
    end
  end

  // stage 5: discriminant and classification
  logic [127:0] d5;
  assign d5 = cneg4_q ? (hsq4_q - ac4_q) : (hsq4_q + ac4_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_o.ok <= oka4_q && !d5[127];
      out_o.h  <= h4_q;
      out_o.a  <= a4_q;
      out_o.d  <= d5;
      out_o.oy <= oy4_q;
      out_o.dy <= dy4_q;
    end
  end

endmodule

// ===== hdl/rcs_fifo.sv =====
module rcs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  rcs_pkg::cls_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output rcs_pkg::cls_t pop_data_o
);

  localparam int unsigned PW = $clog2(rcs_pkg::QDEPTH);

  rcs_pkg::cls_t mem_q [rcs_pkg::QDEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != (PW+1)'(rcs_pkg::QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== hdl/rcs_div.sv =====
module rcs_div #(
  parameter int unsigned FRAC_BITS = rcs_pkg::FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [66+FRAC_BITS-1:0]  num_i,
  input  logic                     neg_i,
  input  logic [63:0]              den_i,
  output logic signed [31:0]       t_o
);

  localparam int unsigned QB = rcs_pkg::QBITS;
  localparam int unsigned NW = 66 + FRAC_BITS;
  localparam int unsigned WW = (NW > 64 + QB + 1) ? NW : 64 + QB + 1;
  localparam logic [QB-1:0] POS_MAX = QB'(64'h7FFF_FFFF);
  localparam logic [QB:0]   NEG_MAX = (QB+1)'(64'h8000_0000);

  logic [WW-1:0] r_q   [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic [63:0]   d_q   [QB+1];
  logic          n_q   [QB+1];
  logic          sat_q [QB+1];

  // quotient of 2^QB or more saturates either way
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= WW'(num_i);
      q_q[0]   <= '0;
      d_q[0]   <= den_i;
      n_q[0]   <= neg_i;
      sat_q[0] <= WW'(num_i) >= (WW'(den_i) << QB);
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int unsigned K = QB - 1 - j;
    logic [WW-1:0] sub;
    logic          ge;
    assign sub = WW'(d_q[j]) << K;
    assign ge  = r_q[j] >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]   <= ge ? (r_q[j] - sub) : r_q[j];
        q_q[j+1]   <= q_q[j] | (ge ? (QB'(1) << K) : '0);
        d_q[j+1]   <= d_q[j];
        n_q[j+1]   <= n_q[j];
        sat_q[j+1] <= sat_q[j];
      end
    end
  end

  // negative roots round toward minus infinity
  logic [QB:0] qc;
  assign qc = {1'b0, q_q[QB]} + (QB+1)'(r_q[QB] != '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (n_q[QB]) begin
        t_o <= (sat_q[QB] || qc > NEG_MAX) ? 32'sh8000_0000 : -signed'(qc[31:0]);
      end else begin
        t_o <= (sat_q[QB] || q_q[QB] > POS_MAX) ? 32'sh7FFF_FFFF : signed'(q_q[QB][31:0]);
      end
    end
  end

endmodule

// ===== hdl/rcs_back.sv =====
module rcs_back #(
  parameter int unsigned FRAC_BITS = rcs_pkg::FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rcs_pkg::cls_t      in_i,
  input  logic signed [31:0] y_min_i,
  input  logic signed [31:0] y_max_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rcs_pkg::hit_t      out_o
);

  localparam int unsigned SQ = 64;
  localparam int unsigned NW = 66 + FRAC_BITS;
  localparam int unsigned DL = rcs_pkg::QBITS + 2;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] oy;
    logic signed [31:0] dy;
  } side_t;

  logic en;
  logic ov_q;

  assign en          = !ov_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = ov_q;

  // square root, one result bit per stage
  logic               sv_q [SQ+1];
  logic [127:0]       sx_q [SQ+1];
  logic [127:0]       sr_q [SQ+1];
  logic signed [64:0] sh_q [SQ+1];
  logic [63:0]        sa_q [SQ+1];
  side_t              ss_q [SQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (en) sv_q[0] <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q[0] <= in_i.d;
      sr_q[0] <= '0;
      sh_q[0] <= in_i.h;
      sa_q[0] <= in_i.a;
      ss_q[0] <= '{ok: in_i.ok, oy: in_i.oy, dy: in_i.dy};
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [127:0] BITV = 128'(1) << (2 * (SQ - 1 - k));
    logic [127:0] trial;
    logic         ge;
    assign trial = sr_q[k] + BITV;
    assign ge    = sx_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else if (en) sv_q[k+1] <= sv_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sx_q[k+1] <= ge ? (sx_q[k] - trial) : sx_q[k];
        sr_q[k+1] <= ge ? ((sr_q[k] >> 1) + BITV) : (sr_q[k] >> 1);
        sh_q[k+1] <= sh_q[k];
        sa_q[k+1] <= sa_q[k];
        ss_q[k+1] <= ss_q[k];
      end
    end
  end

  // numerators -h -/+ sqrt(d), split into sign and scaled magnitude
  logic signed [66:0] hx, sx, n1, n2;
  logic [65:0]        m1, m2;
  logic               nv_q, ng1_q, ng2_q;
  logic [NW-1:0]      nm1_q, nm2_q;
  logic [63:0]        na_q;
  side_t              ns_q;

  assign hx = 67'(sh_q[SQ]);
  assign sx = signed'({3'b000, sr_q[SQ][63:0]});
  assign n1 = -hx - sx;
  assign n2 = -hx + sx;
  assign m1 = n1[66] ? 66'(-n1) : 66'(n1);
  assign m2 = n2[66] ? 66'(-n2) : 66'(n2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nv_q <= 1'b0;
    else if (en) nv_q <= sv_q[SQ];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ng1_q <= n1[66];
      ng2_q <= n2[66];
      nm1_q <= {m1, {FRAC_BITS{1'b0}}};
      nm2_q <= {m2, {FRAC_BITS{1'b0}}};
      na_q  <= sa_q[SQ];
      ns_q  <= ss_q[SQ];
    end
  end

  logic signed [31:0] t1, t2;

  rcs_div #(.FRAC_BITS(FRAC_BITS)) u_div_near (
    .clk_i(clk_i), .en_i(en), .num_i(nm1_q), .neg_i(ng1_q), .den_i(na_q), .t_o(t1)
  );

  rcs_div #(.FRAC_BITS(FRAC_BITS)) u_div_far (
    .clk_i(clk_i), .en_i(en), .num_i(nm2_q), .neg_i(ng2_q), .den_i(na_q), .t_o(t2)
  );

  // side data riding along with the dividers
  logic  dv_q [DL];
  side_t ds_q [DL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else if (en) dv_q[0] <= nv_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) ds_q[0] <= ns_q;
  end

  for (genvar j = 1; j < DL; j++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j] <= 1'b0;
      else if (en) dv_q[j] <= dv_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) ds_q[j] <= ds_q[j-1];
    end
  end

  // height products
  logic               hv_q;
  side_t              hs_q;
  logic signed [31:0] ht1_q, ht2_q;
  logic signed [63:0] p1_q, p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hv_q <= 1'b0;
    else if (en) hv_q <= dv_q[DL-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hs_q  <= ds_q[DL-1];
      ht1_q <= t1;
      ht2_q <= t2;
      p1_q  <= 64'(t1 * ds_q[DL-1].dy);
      p2_q  <= 64'(t2 * ds_q[DL-1].dy);
    end
  end

  // height bound check and output register
  logic signed [63:0] y1, y2;
  logic               in1, in2;

  assign y1  = 64'(hs_q.oy) + (p1_q >>> FRAC_BITS);
  assign y2  = 64'(hs_q.oy) + (p2_q >>> FRAC_BITS);
  assign in1 = hs_q.ok
            && (y_min_i == rcs_pkg::Y_NO_MIN || y1 >= 64'(y_min_i))
            && (y_max_i == rcs_pkg::Y_NO_MAX || y1 <= 64'(y_max_i));
  assign in2 = hs_q.ok
            && (y_min_i == rcs_pkg::Y_NO_MIN || y2 >= 64'(y_min_i))
            && (y_max_i == rcs_pkg::Y_NO_MAX || y2 <= 64'(y_max_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= hv_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_o.near_valid <= in1;
      out_o.near_t     <= in1 ? ht1_q : '0;
      out_o.far_valid  <= in2;
      out_o.far_t      <= in2 ? ht2_q : '0;
    end
  end

endmodule

// ===== hdl/ray_cylinder_side_intersect.sv =====
// Stages: 5 classify stages, then the queue, then 103 solve stages.
// Throughput: one ray per cycle while the hit side is ready, set by the fully
//   staged 64-step square root and the two 33-step root dividers.
// Reset: async active low; clears all valid flags and the queue, loads the
//   bound registers with "unbounded" and the parallel epsilon with 1.
module ray_cylinder_side_intersect #(
  parameter int unsigned FRAC_BITS = rcs_pkg::FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rcs_ray_if.sink                          ray_i,
  rcs_hit_if.source                        hit_o,
  input  logic                             cfg_we_i,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rcs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // configuration registers
  logic signed [31:0] y_min_q, y_max_q;
  logic [15:0]        eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_min_q <= rcs_pkg::Y_NO_MIN;
      y_max_q <= rcs_pkg::Y_NO_MAX;
      eps_q   <= rcs_pkg::EPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rcs_pkg::CFG_Y_MIN: y_min_q <= signed'(cfg_data_i[31:0]);
        rcs_pkg::CFG_Y_MAX: y_max_q <= signed'(cfg_data_i[31:0]);
        rcs_pkg::CFG_EPS:   eps_q   <= cfg_data_i[15:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // front: products, discriminant, parallel / miss classification
  logic          f_valid, q_ready;
  rcs_pkg::cls_t f_data;

  rcs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ray_i.valid),
    .in_ready_o  (ray_i.ready),
    .in_i        (ray_i.ray),
    .eps_i       (eps_q),
    .out_valid_o (f_valid),
    .out_ready_i (q_ready),
    .out_o       (f_data)
  );

  // short queue decouples classify stalls from solve stalls
  logic          q_valid, b_ready;
  rcs_pkg::cls_t q_data;

  rcs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (q_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_data)
  );

  // back: sqrt, root division with saturation, height window, output reg
  rcs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (b_ready),
    .in_i        (q_data),
    .y_min_i     (y_min_q),
    .y_max_i     (y_max_q),
    .out_valid_o (hit_o.valid),
    .out_ready_i (hit_o.ready),
    .out_o       (hit_o.hit)
  );

`ifndef SYNTHESIS
  // front only backs up when the queue is full
  a_front_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ray_i.ready |-> (f_valid && !q_ready))
    else $error("front stalled with queue space free");

  // back only refuses the queue head when the output is blocked
  a_back_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !b_ready |-> (hit_o.valid && !hit_o.ready))
    else $error("back stalled without output backpressure");

  // a missed near root carries a zero parameter
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_o.valid && !hit_o.hit.near_valid) |-> (hit_o.hit.near_t == '0))
    else $error("near_t nonzero on miss");
`endif

endmodule

// ===== tb/sv/ray_cylinder_side_intersect_test.sv =====
module ray_cylinder_side_intersect_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcs_pkg::*;

  // write to an index with no register behind it; the block drops it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FRAC_BITS);
  // cycles with no transaction on either side before the run is given up
  localparam int unsigned STALL_LIMIT = 5000;
  // let the pipeline empty with some margin
  localparam int unsigned FLUSH_CYCLES = 150;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rcs_ray_if ray_bus();
  rcs_hit_if hit_bus();

  ray_cylinder_side_intersect uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ray_i      (ray_bus),
    .hit_o      (hit_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // local copy of the register file
  logic signed [31:0] lo_bound;
  logic signed [31:0] hi_bound;
  logic [15:0] par_eps;

  hit_t pending_hits[$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // floor square root of a nonnegative 128-bit value, one bit per step
  function automatic logic [63:0] floor_sqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] cand;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (({64'd0, cand} * {64'd0, cand}) <= n) r = cand;
    end
    return r;
  endfunction

  // floor(num * 2^FRAC_BITS / den), saturated to 32 bit signed
  function automatic logic signed [31:0] root_param(logic signed [127:0] num,
                                                   logic [63:0] den);
    logic neg;
    logic [127:0] mag;
    logic [127:0] sh;
    logic [127:0] q;
    logic [127:0] rem;
    logic [31:0] lowq;
    neg = num[127];
    mag = neg ? -num : num;
    sh = mag << FRAC_BITS;
    q = sh / {64'd0, den};
    rem = sh % {64'd0, den};
    if (neg) begin
      if (rem != 0) q = q + 1;
      if (q > 128'h8000_0000) return 32'sh8000_0000;
      lowq = q[31:0];
      return -lowq;
    end
    if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return q[31:0];
  endfunction

  // hit height oy + floor(t*dy / 2^FRAC_BITS) against the bounds
  function automatic logic within_height(logic signed [31:0] t, logic signed [31:0] oy,
                                         logic signed [31:0] dy);
    logic signed [63:0] tt;
    logic signed [63:0] dd;
    logic signed [63:0] p;
    logic signed [63:0] y;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    tt = t;
    dd = dy;
    p = tt * dd;
    y = oy;
    y = y + (p >>> FRAC_BITS);
    lo = lo_bound;
    hi = hi_bound;
    if (lo_bound != Y_NO_MIN && y < lo) return 1'b0;
    if (hi_bound != Y_NO_MAX && y > hi) return 1'b0;
    return 1'b1;
  endfunction

  function automatic hit_t predict_side_hit(ray_t r);
    logic signed [63:0] ox, oy, oz, dx, dy, dz;
    logic [63:0] a;
    logic [63:0] csq;
    logic signed [127:0] h;
    logic signed [127:0] hmag;
    logic signed [127:0] ac;
    logic signed [127:0] disc;
    logic signed [127:0] s;
    logic signed [31:0] t1, t2;
    hit_t res;
    ox = r.origin_x;
    oy = r.origin_y;
    oz = r.origin_z;
    dx = r.dir_x;
    dy = r.dir_y;
    dz = r.dir_z;
    a = dx * dx + dz * dz;
    csq = ox * ox + oz * oz;
    res = '0;
    if (a != 0 && a >= ({48'd0, par_eps} << FRAC_BITS)) begin
      h = ox * dx + oz * dz;
      hmag = h[127] ? -h : h;
      if (csq >= ONE_SQ)
        ac = -($signed({64'd0, a}) * $signed({64'd0, csq - ONE_SQ}));
      else
        ac = $signed({64'd0, a}) * $signed({64'd0, ONE_SQ - csq});
      disc = hmag * hmag + ac;
      if (!disc[127]) begin
        s = $signed({64'd0, floor_sqrt(disc)});
        t1 = root_param(-h - s, a);
        t2 = root_param(-h + s, a);
        if (within_height(t1, r.origin_y, r.dir_y)) begin
          res.near_valid = 1'b1;
          res.near_t = t1;
        end
        if (within_height(t2, r.origin_y, r.dir_y)) begin
          res.far_valid = 1'b1;
          res.far_t = t2;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    fail_count++;
  endtask

  // result side: compare each hit transaction with the oldest prediction
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && hit_bus.valid && hit_bus.ready) begin
      if (pending_hits.size() == 0) begin
        $display("unexpected hit transaction %h", hit_bus.hit);
        fail_count++;
      end else begin
        want = pending_hits.pop_front();
        if (hit_bus.hit.near_valid !== want.near_valid)
          report_mismatch("near_valid", hit_bus.hit.near_valid, want.near_valid);
        if (hit_bus.hit.near_t !== want.near_t)
          report_mismatch("near_t", hit_bus.hit.near_t, want.near_t);
        if (hit_bus.hit.far_valid !== want.far_valid)
          report_mismatch("far_valid", hit_bus.hit.far_valid, want.far_valid);
        if (hit_bus.hit.far_t !== want.far_t)
          report_mismatch("far_t", hit_bus.hit.far_t, want.far_t);
      end
    end
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk_i) begin
    hit_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog: any transaction on either side resets the count
  always @(posedge clk_i) begin
    if (!rst_ni || (ray_bus.valid && ray_bus.ready) || (hit_bus.valid && hit_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ray_cylinder_side_intersect_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one ray transaction; valid stays high if the next call follows at once
  task automatic send_ray(ray_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      ray_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    ray_bus.valid <= 1'b1;
    ray_bus.ray <= r;
    forever begin
      @(posedge clk_i);
      if (ray_bus.ready) break;
      @(negedge clk_i);
    end
    pending_hits.push_back(predict_side_hit(r));
    @(negedge clk_i);
  endtask

  // drop valid, wait until every prediction has been matched, then idle for FLUSH_CYCLES
  task automatic wait_drained();
    ray_bus.valid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk_i);
    repeat (FLUSH_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_Y_MIN: lo_bound = value;
      CFG_Y_MAX: hi_bound = value;
      CFG_EPS:   par_eps = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] near_zero(int unsigned m);
    int v;
    v = int'($urandom_range(0, 2 * m)) - int'(m);
    return v;
  endfunction

  // mostly rays near the unit cylinder so roots and heights matter;
  // the rest nearly axis-parallel, full-range noise or extremes
  function automatic ray_t random_ray();
    ray_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      r.origin_x = near_zero(32'h4_0000);
      r.origin_y = near_zero(32'h4_0000);
      r.origin_z = near_zero(32'h4_0000);
      r.dir_x = near_zero(32'h2_0000);
      r.dir_y = near_zero(32'h2_0000);
      r.dir_z = near_zero(32'h2_0000);
    end else if (pick < 80) begin
      // nearly parallel to the axis, around the epsilon threshold
      r.origin_x = near_zero(32'h2_0000);
      r.origin_y = near_zero(32'h4_0000);
      r.origin_z = near_zero(32'h2_0000);
      r.dir_x = near_zero(32'h400);
      r.dir_y = near_zero(32'h2_0000);
      r.dir_z = near_zero(32'h400);
    end else if (pick < 95) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      r.origin_x = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      r.origin_y = $urandom;
      r.origin_z = $urandom_range(0, 1) ? 32'sh8000_0000 : near_zero(32'h1_0000);
      r.dir_x = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      r.dir_y = $urandom;
      r.dir_z = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh0000_0001;
    end
    return r;
  endfunction

  task automatic send_random_rays(int unsigned n);
    repeat (n) send_ray(random_ray());
  endtask

  function automatic ray_t mk_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                                  logic signed [31:0] oz, logic signed [31:0] dx,
                                  logic signed [31:0] dy, logic signed [31:0] dz);
    ray_t r;
    r.origin_x = ox;
    r.origin_y = oy;
    r.origin_z = oz;
    r.dir_x = dx;
    r.dir_y = dy;
    r.dir_z = dz;
    return r;
  endfunction

  // special cases under reset settings, Q16.16 constants
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_ray(mk_ray(0, 0, 0, 0, 0, 0));                          // zero direction
    send_ray(mk_ray(0, 0, 0, 0, 32'sh1_0000, 0));                // along the axis
    send_ray(mk_ray(0, 0, 32'sh5_0000, 32'sh1_0000, 0, 0));      // misses: d < 0
    send_ray(mk_ray(0, 0, 32'sh1_0000, 32'sh1_0000, 0, 0));      // tangent: d = 0
    send_ray(mk_ray(-32'sh2_0000, 0, 0, 32'sh1_0000, 32'sh8000, 0)); // clean two hits
    send_ray(mk_ray(0, 0, 0, 32'sh1_0000, 0, 32'sh1_0000));      // origin inside
    send_ray(mk_ray(32'sh3_0000, 32'sh1_0000, 0, -32'sh1_0000, -32'sh1_0000, 0));
    send_ray(mk_ray(0, 0, 0, 1, 0, 0));                          // a below epsilon
    send_ray(mk_ray(0, 0, 0, 32'sh100, 0, 0));                   // a exactly at epsilon
    send_ray(mk_ray(32'sh7FFF_FFFF, 0, 0, 32'sh100, 0, 0));      // saturating roots
    send_ray(mk_ray(32'sh8000_0000, 0, 0, 32'sh100, 0, 0));
    send_ray(mk_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_ray(mk_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                    32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_ray(mk_ray(-1, -1, -1, -1, -1, -1));
    send_ray(mk_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF,
                    32'sh8000_0000, 32'sh8000_0000));
    send_ray(mk_ray(0, 32'sh7FFF_0000, 0, 32'sh1_0000, 32'sh7FFF_FFFF, 0));
    wait_drained();
  endtask

  // height window: finite bounds, near-extreme bounds, empty, and single-sided either way
  task automatic test_height_bounds();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    write_reg(CFG_Y_MIN, -32'sh1_0000);
    write_reg(CFG_Y_MAX, 32'sh1_0000);
    send_ray(mk_ray(-32'sh2_0000, 0, 0, 32'sh1_0000, 32'sh8000, 0));
    send_random_rays(150);
    wait_drained();
    write_reg(CFG_Y_MIN, 32'sh8000_0001);
    write_reg(CFG_Y_MAX, 32'sh7FFF_FFFE);
    send_random_rays(100);
    wait_drained();
    write_reg(CFG_Y_MIN, 32'sh2_0000);
    write_reg(CFG_Y_MAX, -32'sh2_0000);
    send_random_rays(60);
    wait_drained();
    write_reg(CFG_Y_MIN, Y_NO_MIN);
    write_reg(CFG_Y_MAX, near_zero(32'h2_0000));
    send_random_rays(100);
    wait_drained();
    write_reg(CFG_Y_MIN, near_zero(32'h2_0000));
    write_reg(CFG_Y_MAX, Y_NO_MAX);
    send_random_rays(100);
    wait_drained();
  endtask

  // parallel threshold at both ends and in between; upper data bits ignored
  task automatic test_epsilon();
    send_idle_pct = 20;
    recv_stall_pct = 20;
    write_reg(CFG_EPS, 32'h0000_0000);
    send_ray(mk_ray(0, 0, 0, 1, 0, 0));
    send_random_rays(100);
    wait_drained();
    write_reg(CFG_EPS, 32'hFFFF_FFFF);
    send_ray(mk_ray(0, 0, 0, 32'sh1_0000, 0, 0));
    send_ray(mk_ray(0, 0, 0, 32'sh0_FFFF, 0, 32'sh100));
    send_random_rays(100);
    wait_drained();
    write_reg(CFG_EPS, $urandom);
    send_random_rays(100);
    wait_drained();
    write_reg(CFG_EPS, {16'hA5A5, EPS_RESET});
  endtask

  // an index with no register must leave the settings untouched
  task automatic test_unused_index();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_UNUSED;
    cfg_data_i <= $urandom;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    send_random_rays(60);
    wait_drained();
  endtask

  // flow control phases with random settings in between
  task automatic test_flow_control();
    write_reg(CFG_Y_MIN, near_zero(32'h3_0000));
    write_reg(CFG_Y_MAX, 32'sh3_0000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_rays(250);
    send_idle_pct = 66;
    send_random_rays(250);
    wait_drained();
    write_reg(CFG_Y_MIN, Y_NO_MIN);
    write_reg(CFG_EPS, $urandom_range(0, 16));
    send_idle_pct = 0;
    recv_stall_pct = 66;
    send_random_rays(250);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    send_random_rays(200);
    wait_drained();
  endtask

  // sender holds off until the pipeline is empty, then streams again
  task automatic test_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 29;
    send_random_rays(40);
    ray_bus.valid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk_i);
    send_random_rays(40);
    wait_drained();
  endtask

  initial begin
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    lo_bound = Y_NO_MIN;
    hi_bound = Y_NO_MAX;
    par_eps = EPS_RESET;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_Y_MIN;
    cfg_data_i = '0;
    ray_bus.valid = 1'b0;
    ray_bus.ray = '0;
    hit_bus.ready = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_height_bounds();
    test_epsilon();
    test_unused_index();
    test_flow_control();
    test_hold_off();

    if (fail_count == 0) begin
      $display("ray_cylinder_side_intersect_test OK");
    end else begin
      $display("ray_cylinder_side_intersect_test NOT OK");
    end
    $finish;
  end

endmodule
